/* hw/rtl/two_fifo_strict_priority_server_top_defines.svh */
// Assertion macros for the two-queue strict-priority server.
`ifndef TWO_FIFO_STRICT_PRIORITY_SERVER_TOP_DEFINES_SVH
`define TWO_FIFO_STRICT_PRIORITY_SERVER_TOP_DEFINES_SVH

// Property that holds on every clock edge out of reset
`define TSPS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent
`define TSPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define TSPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tsps_pkg.sv */
// Shared types, codes and defaults of the two-queue strict-priority server.
`default_nettype none

package tsps_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int ID_WIDTH_DEF    = 16;

    localparam int OP_W     = 2;
    localparam int PORT_ID_W = 16;
    localparam int OCC_W    = 7;
    localparam int LIMIT_W  = 7;
    localparam int TOTAL_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    // Request codes
    typedef enum logic [OP_W-1:0] {
        OP_ENQ_HIGH = 2'd0,
        OP_ENQ_LOW  = 2'd1,
        OP_TICK     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIGH_Q = 3'd0,
        ST_HIGH_D = 3'd1,
        ST_LOW_Q  = 3'd2,
        ST_LOW_D  = 3'd3,
        ST_HIGH_S = 3'd4,
        ST_LOW_S  = 3'd5,
        ST_IDLE   = 3'd6
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIGH_LIMIT = 2'd0,
        CFG_LOW_LIMIT  = 2'd1
    } t_cfg_idx;

    // Event total slots
    typedef enum logic [2:0] {
        EV_HS = 3'd0,
        EV_LS = 3'd1,
        EV_HD = 3'd2,
        EV_LD = 3'd3,
        EV_HI = 3'd4,
        EV_LI = 3'd5
    } t_event;

    localparam int EV_NUM = 6;

    // Per-queue control from the scheduler
    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctrl;

    // Saturating increment of a total
    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] val,
                                                   input logic inc);
        logic [TOTAL_W-1:0] res;
        res = val;
        if (inc && (val != {TOTAL_W{1'b1}})) begin
            res = val + 1'b1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/two_fifo_strict_priority_server_top.sv */
// Top level of the two-queue strict-priority server.
`default_nettype none
`include "two_fifo_strict_priority_server_top_defines.svh"

// Takes one request per clock: busy stays low, so start may be held high every
// cycle. The result of a request accepted at one edge is on the result ports,
// with o_valid high, for exactly the following cycle; the receiver cannot stall
// it. A served identifier comes from the registered read of the queue
// memories. Queue, counter and total updates all land at the accepting edge.
// The queue memories are not cleared after reset; only entries written by an
// enqueue are ever served. Limits are written through the configuration
// channel, which is always ready.
module two_fifo_strict_priority_server_top
    import tsps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic [PORT_ID_W-1:0]  i_item_id,
    // configuration channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [LIMIT_W-1:0]    i_cfg_data,
    // result channel
    output logic                       o_valid,
    output logic [2:0]                 o_status,
    output logic [PORT_ID_W-1:0]       o_result_id,
    output logic [OCC_W-1:0]           o_high_occupancy,
    output logic [OCC_W-1:0]           o_low_occupancy,
    output logic [TOTAL_W-1:0]         o_high_served_total,
    output logic [TOTAL_W-1:0]         o_low_served_total,
    output logic [TOTAL_W-1:0]         o_high_dropped_total,
    output logic [TOTAL_W-1:0]         o_low_dropped_total,
    output logic [TOTAL_W-1:0]         o_high_idle_total,
    output logic [TOTAL_W-1:0]         o_low_idle_total
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                 accept;
    logic [ID_WIDTH-1:0]  item_id;
    t_q_ctrl              h_ctrl;
    t_q_ctrl              l_ctrl;
    logic [CW-1:0]        h_count;
    logic [CW-1:0]        l_count;
    logic                 h_can_push;
    logic                 l_can_push;
    logic [ID_WIDTH-1:0]  h_head_id;
    logic [ID_WIDTH-1:0]  l_head_id;

    logic [LIMIT_W-1:0]   r_high_limit;
    logic [LIMIT_W-1:0]   r_low_limit;
    logic                 r_valid;
    t_status              r_status;
    t_status              n_status;
    logic [PORT_ID_W-1:0] r_id;
    logic [TOTAL_W-1:0]   r_totals [EV_NUM];
    logic [EV_NUM-1:0]    ev_inc;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign item_id     = ID_WIDTH'(i_item_id);

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_limit <= LIMIT_RESET;
            r_low_limit  <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HIGH_LIMIT: r_high_limit <= i_cfg_data;
                CFG_LOW_LIMIT:  r_low_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request decode: queue controls, status and event increments
    always_comb begin
        h_ctrl   = '0;
        l_ctrl   = '0;
        n_status = ST_IDLE;
        ev_inc   = '0;
        if (accept) begin
            unique case (i_operation)
                OP_ENQ_HIGH: begin
                    h_ctrl.push = h_can_push;
                    n_status    = h_can_push ? ST_HIGH_Q : ST_HIGH_D;
                    ev_inc[EV_HD] = !h_can_push;
                end
                OP_ENQ_LOW: begin
                    l_ctrl.push = l_can_push;
                    n_status    = l_can_push ? ST_LOW_Q : ST_LOW_D;
                    ev_inc[EV_LD] = !l_can_push;
                end
                OP_TICK: begin
                    if (h_count != '0) begin
                        h_ctrl.pop    = 1'b1;
                        n_status      = ST_HIGH_S;
                        ev_inc[EV_HS] = 1'b1;
                        ev_inc[EV_LI] = 1'b1;
                    end else if (l_count != '0) begin
                        l_ctrl.pop    = 1'b1;
                        n_status      = ST_LOW_S;
                        ev_inc[EV_LS] = 1'b1;
                        ev_inc[EV_HI] = 1'b1;
                    end else begin
                        ev_inc[EV_HI] = 1'b1;
                        ev_inc[EV_LI] = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // High-priority queue
    tsps_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_high_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit    (r_high_limit),
        .i_ctrl     (h_ctrl),
        .i_push_id  (item_id),
        .o_count    (h_count),
        .o_can_push (h_can_push),
        .o_head_id  (h_head_id)
    );

    // Low-priority queue
    tsps_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_low_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_limit    (r_low_limit),
        .i_ctrl     (l_ctrl),
        .i_push_id  (item_id),
        .o_count    (l_count),
        .o_can_push (l_can_push),
        .o_head_id  (l_head_id)
    );

    // Saturating event totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < EV_NUM; k++) begin
                r_totals[k] <= '0;
            end
        end else begin
            for (int k = 0; k < EV_NUM; k++) begin
                r_totals[k] <= sat_inc(r_totals[k], ev_inc[k]);
            end
        end
    end

    // Result strobe and registered status / request id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_id     <= PORT_ID_W'(item_id);
        end
    end

    // Result id: served ids come straight from the memory read data
    always_comb begin
        case (r_status)
            ST_HIGH_S: o_result_id = PORT_ID_W'(h_head_id);
            ST_LOW_S:  o_result_id = PORT_ID_W'(l_head_id);
            ST_IDLE:   o_result_id = '0;
            default:   o_result_id = r_id;
        endcase
    end

    assign o_valid              = r_valid;
    assign o_status             = r_status;
    assign o_high_occupancy     = OCC_W'(h_count);
    assign o_low_occupancy      = OCC_W'(l_count);
    assign o_high_served_total  = r_totals[EV_HS];
    assign o_low_served_total   = r_totals[EV_LS];
    assign o_high_dropped_total = r_totals[EV_HD];
    assign o_low_dropped_total  = r_totals[EV_LD];
    assign o_high_idle_total    = r_totals[EV_HI];
    assign o_low_idle_total     = r_totals[EV_LI];

    // Checks
    `TSPS_ASSERT_ALWAYS(a_high_bound, h_count <= CW'(QUEUE_DEPTH), "high queue over capacity")
    `TSPS_ASSERT_NEXT(a_result_follows, accept, o_valid, "accepted request gave no result")
    `TSPS_ASSERT_SAME(a_high_pop, o_valid && (r_status == ST_HIGH_S) && $past(i_rst_n), h_count == ($past(h_count) - 1'b1), "high serve did not pop")
    `TSPS_ASSERT_SAME(a_low_pop, o_valid && (r_status == ST_LOW_S) && $past(i_rst_n), (l_count == ($past(l_count) - 1'b1)) && ($past(h_count) == '0), "low served while high waiting")

endmodule

`default_nettype wire

/* hw/rtl/tsps_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/tsps_queue.sv */
// Bounded circular FIFO of identifiers: head, count, admission check and store.
`default_nettype none

module tsps_queue
    import tsps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [LIMIT_W-1:0]                 i_limit,
    input  wire t_q_ctrl                            i_ctrl,
    input  wire logic [ID_WIDTH-1:0]                i_push_id,
    output logic      [$clog2(QUEUE_DEPTH+1)-1:0]   o_count,
    output logic                                    o_can_push,
    output logic      [ID_WIDTH-1:0]                o_head_id
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

    logic [AW-1:0] r_head;
    logic [AW-1:0] n_head;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail_addr;

    // Admission: fewer items than both the limit and the capacity
    assign o_can_push = (r_count < CW'(QUEUE_DEPTH)) &&
                        (CMPW'(r_count) < CMPW'(i_limit));

    // Tail = head + count, wrapped once
    assign tail_sum  = SW'(r_head) + SW'(r_count);
    assign tail_addr = (tail_sum >= SW'(QUEUE_DEPTH))
                     ? AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);

    // Head and count update
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_ctrl.pop) begin
            n_head  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end else if (i_ctrl.push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Store: write at tail, head is read every cycle
    tsps_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.push),
        .i_waddr (tail_addr),
        .i_wdata (i_push_id),
        .i_raddr (r_head),
        .o_rdata (o_head_id)
    );

    assign o_count = r_count;

endmodule

`default_nettype wire
